/* rtl/core/smlb_pkg.sv */
// Shared types and codes of the loop, branch and return-stack unit.
// Used by smlb_cell, smlb_ctrl and stack_machine_loop_branch_unit.
// No dependencies.
`default_nettype none

package smlb_pkg;

  // control actions
  typedef enum logic [3:0] {
    ACT_BRANCH      = 4'd0,
    ACT_ZERO_BRANCH = 4'd1,
    ACT_QDO         = 4'd2,
    ACT_DO          = 4'd3,
    ACT_LOOP        = 4'd4,
    ACT_STEP_LOOP   = 4'd5,
    ACT_LEAVE       = 4'd6,
    ACT_UNLOOP      = 4'd7,
    ACT_READ_I      = 4'd8,
    ACT_READ_J      = 4'd9,
    ACT_EXIT        = 4'd10,
    ACT_CALL_PUSH   = 4'd11,
    ACT_RETURN_POP  = 4'd12
  } smlb_action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } smlb_status_e;

  // shift move of the return-stack cell chain (cell 0 is the top)
  typedef enum logic [2:0] {
    SH_HOLD  = 3'd0,
    SH_PUSH1 = 3'd1,
    SH_PUSH2 = 3'd2,
    SH_POP1  = 3'd3,
    SH_POP2  = 3'd4
  } smlb_shift_e;

  // number of top cells that the control can load directly
  localparam int unsigned LoadCells = 3;

  // input transaction
  typedef struct packed {
    logic [3:0]         action;
    logic [1:0]         data_count;
    logic signed [31:0] top_value;
    logic signed [31:0] second_value;
    logic signed [31:0] inline_offset;
    logic [31:0]        call_address;
  } smlb_req_t;

  // result transaction
  typedef struct packed {
    logic [31:0]        next_pointer;
    logic               pointer_valid;
    logic [1:0]         data_pops;
    logic               push_valid;
    logic signed [31:0] push_value;
    logic               exit_request;
    logic [1:0]         status;
  } smlb_res_t;

  // control from the decoder to the cell chain
  typedef struct packed {
    smlb_shift_e                     shift;
    logic [LoadCells-1:0]            ld_en;
    logic [LoadCells-1:0][31:0]      ld_val;
  } smlb_stk_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/smlb_cell.sv */
// One return-stack cell: holds one 32-bit entry and takes a neighbor's value
// on a push or pop. Depends on smlb_pkg.
`default_nettype none

module smlb_cell
  import smlb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire smlb_shift_e shift_i,
  input  wire logic        ld_en_i,
  input  wire logic [31:0] ld_val_i,
  input  wire logic [31:0] up1_i,   // neighbor one closer to the top
  input  wire logic [31:0] up2_i,   // neighbor two closer to the top
  input  wire logic [31:0] dn1_i,   // neighbor one deeper
  input  wire logic [31:0] dn2_i,   // neighbor two deeper
  output logic      [31:0] q_o
);

  logic [31:0] val_d, val_q;

  // direct load wins over the shift move
  always_comb begin
    val_d = val_q;
    if (ld_en_i) begin
      val_d = ld_val_i;
    end else begin
      case (shift_i)
        SH_PUSH1: val_d = up1_i;
        SH_PUSH2: val_d = up2_i;
        SH_POP1:  val_d = dn1_i;
        SH_POP2:  val_d = dn2_i;
        default:  val_d = val_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

/* rtl/core/smlb_ctrl.sv */
// Action decoder: checks depth and operands, computes loop and pointer
// arithmetic from the top cells, and drives the cell chain. Depends on smlb_pkg.
`default_nettype none

module smlb_ctrl
  import smlb_pkg::*;
#(
  parameter int unsigned RSTACK_DEPTH = 64,
  parameter int unsigned CELL_BYTES   = 4,
  localparam int unsigned DepthW      = $clog2(RSTACK_DEPTH + 1)
) (
  input  wire logic              valid_i,
  input  wire smlb_req_t         req_i,
  input  wire logic [DepthW-1:0] depth_i,
  input  wire logic [31:0]       c0_i,
  input  wire logic [31:0]       c1_i,
  input  wire logic [31:0]       c2_i,
  input  wire logic [31:0]       c3_i,
  output smlb_stk_ctl_t          ctl_o,
  output logic [DepthW-1:0]      depth_o,
  output logic [1:0]             pops_o,
  output logic                   push_valid_o,
  output logic [31:0]            push_value_o,
  output logic                   exit_o,
  output smlb_status_e           status_o
);

  localparam logic [DepthW-1:0] DepthMax  = DepthW'(RSTACK_DEPTH);
  localparam logic [DepthW-1:0] DepthMax2 = DepthW'(RSTACK_DEPTH - 2);
  localparam logic [31:0]       CellInc   = 32'(CELL_BYTES);

  logic [31:0] top_u, second_u, offs_u;
  logic [31:0] ip_plus_offs, ip_plus_cell, loop_idx, loop_inc;
  logic        loop_cont, d_zero, d_lt3, d_lt5;

  assign top_u        = req_i.top_value;
  assign second_u     = req_i.second_value;
  assign offs_u       = req_i.inline_offset;
  assign ip_plus_offs = c0_i + offs_u;
  assign ip_plus_cell = c0_i + CellInc;
  assign d_zero       = (depth_i == '0);
  assign d_lt3        = (depth_i < DepthW'(3));
  assign d_lt5        = (depth_i < DepthW'(5));

  // loop index step and limit test, signed against the frame limit in cell 2
  always_comb begin
    loop_inc = (req_i.action == ACT_LOOP) ? 32'd1 : top_u;
    loop_idx = c1_i + loop_inc;
    if (req_i.action == ACT_STEP_LOOP && top_u[31]) begin
      loop_cont = ($signed(loop_idx) >= $signed(c2_i));
    end else begin
      loop_cont = ($signed(loop_idx) < $signed(c2_i));
    end
  end

  // action decode
  always_comb begin
    ctl_o        = '{shift: SH_HOLD, ld_en: '0, ld_val: '0};
    depth_o      = depth_i;
    pops_o       = 2'd0;
    push_valid_o = 1'b0;
    push_value_o = '0;
    exit_o       = 1'b0;
    status_o     = ST_OK;
    case (req_i.action)
      ACT_BRANCH: begin
        if (d_zero) begin
          status_o = ST_MISSING;
        end else begin
          ctl_o.ld_en[0]  = 1'b1;
          ctl_o.ld_val[0] = ip_plus_offs;
        end
      end
      ACT_ZERO_BRANCH: begin
        if (d_zero) begin
          status_o = ST_MISSING;
        end else if (req_i.data_count == 2'd0) begin
          status_o = ST_UNDERFLOW;
        end else begin
          pops_o          = 2'd1;
          ctl_o.ld_en[0]  = 1'b1;
          ctl_o.ld_val[0] = (top_u == '0) ? ip_plus_offs : ip_plus_cell;
        end
      end
      ACT_QDO, ACT_DO: begin
        if (d_zero) begin
          status_o = ST_MISSING;
        end else if (req_i.data_count < 2'd2) begin
          status_o = ST_UNDERFLOW;
        end else begin
          pops_o = 2'd2;
          if (req_i.action == ACT_QDO && top_u == second_u) begin
            // empty range: branch past the loop
            ctl_o.ld_en[0]  = 1'b1;
            ctl_o.ld_val[0] = ip_plus_offs;
          end else if (depth_i > DepthMax2) begin
            status_o = ST_OVERFLOW;
          end else begin
            // frame: limit, index, then the pointer on top
            ctl_o.shift     = SH_PUSH2;
            ctl_o.ld_en     = '1;
            ctl_o.ld_val[0] = (req_i.action == ACT_QDO) ? ip_plus_cell : c0_i;
            ctl_o.ld_val[1] = top_u;
            ctl_o.ld_val[2] = second_u;
            depth_o         = depth_i + DepthW'(2);
          end
        end
      end
      ACT_LOOP, ACT_STEP_LOOP: begin
        if (req_i.action == ACT_STEP_LOOP && req_i.data_count == 2'd0) begin
          status_o = ST_UNDERFLOW;
        end else if (d_lt3) begin
          status_o = ST_MISSING;
        end else begin
          pops_o = (req_i.action == ACT_STEP_LOOP) ? 2'd1 : 2'd0;
          if (loop_cont) begin
            ctl_o.ld_en[1:0] = 2'b11;
            ctl_o.ld_val[0]  = ip_plus_offs;
            ctl_o.ld_val[1]  = loop_idx;
          end else begin
            ctl_o.shift     = SH_POP2;
            ctl_o.ld_en[0]  = 1'b1;
            ctl_o.ld_val[0] = ip_plus_cell;
            depth_o         = depth_i - DepthW'(2);
          end
        end
      end
      ACT_LEAVE: begin
        if (d_lt3) begin
          status_o = ST_MISSING;
        end else begin
          ctl_o.ld_en[1]  = 1'b1;
          ctl_o.ld_val[1] = c2_i;
        end
      end
      ACT_UNLOOP: begin
        if (d_lt3) begin
          status_o = ST_MISSING;
        end else begin
          ctl_o.shift     = SH_POP2;
          ctl_o.ld_en[0]  = 1'b1;
          ctl_o.ld_val[0] = c0_i;
          depth_o         = depth_i - DepthW'(2);
        end
      end
      ACT_READ_I: begin
        if (d_lt3) begin
          status_o = ST_MISSING;
        end else begin
          push_valid_o = 1'b1;
          push_value_o = c1_i;
        end
      end
      ACT_READ_J: begin
        if (d_lt5) begin
          status_o = ST_MISSING;
        end else begin
          push_valid_o = 1'b1;
          push_value_o = c3_i;
        end
      end
      ACT_EXIT: begin
        if (d_zero) begin
          status_o = ST_MISSING;
        end else begin
          exit_o = 1'b1;
        end
      end
      ACT_CALL_PUSH: begin
        if (depth_i >= DepthMax) begin
          status_o = ST_OVERFLOW;
        end else begin
          ctl_o.shift     = SH_PUSH1;
          ctl_o.ld_en[0]  = 1'b1;
          ctl_o.ld_val[0] = req_i.call_address;
          depth_o         = depth_i + DepthW'(1);
        end
      end
      ACT_RETURN_POP: begin
        if (d_zero) begin
          status_o = ST_MISSING;
        end else begin
          ctl_o.shift = SH_POP1;
          depth_o     = depth_i - DepthW'(1);
        end
      end
      default: begin
        status_o = ST_OK;
      end
    endcase
    // no transaction: leave the stack alone
    if (!valid_i) begin
      ctl_o   = '{shift: SH_HOLD, ld_en: '0, ld_val: '0};
      depth_o = depth_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stack_machine_loop_branch_unit.sv */
// Top level of the loop, branch and return-stack unit of a stack processor.
// Depends on smlb_pkg, smlb_ctrl and smlb_cell.
`default_nettype none

// The unit executes one control action per clock cycle: a transaction taken
// at a rising edge with start high shows its result on res_o in the cycle
// after that edge, marked by done_o, and busy never rises, so start may
// stay high every cycle. This rate rests on the cell chain: every action
// reads at most the four top cells and moves the whole stack by at most two
// places at once. The return stack is a chain of RSTACK_DEPTH
// cells with the instruction pointer in cell 0; entries are not cleared at
// reset and there is no clearing pass, only the depth counter and done_o reset.
// The result cannot be held off: a receiver must take it in that cycle.
module stack_machine_loop_branch_unit
  import smlb_pkg::*;
#(
  parameter int unsigned RSTACK_DEPTH = 64,
  parameter int unsigned CELL_BYTES   = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire smlb_req_t req_i,
  output logic           done_o,
  output smlb_res_t      res_o
);

  localparam int unsigned DepthW = $clog2(RSTACK_DEPTH + 1);

  logic                    fire;
  smlb_stk_ctl_t           stk_ctl;
  logic [DepthW-1:0]       depth_d, depth_q;
  logic [RSTACK_DEPTH+3:0][31:0] chain;   // cell k sits at chain[k+2]
  logic [1:0]              pops_d, pops_q;
  logic                    pv_d, pv_q;
  logic [31:0]             pval_d, pval_q;
  logic                    ex_d, ex_q;
  smlb_status_e            st_d;
  logic [1:0]              st_q;
  logic                    done_q;

  // one transaction per cycle
  assign busy = 1'b0;
  assign fire = start && !busy;

  // decoder
  smlb_ctrl #(
    .RSTACK_DEPTH (RSTACK_DEPTH),
    .CELL_BYTES   (CELL_BYTES)
  ) u_ctrl (
    .valid_i      (fire),
    .req_i        (req_i),
    .depth_i      (depth_q),
    .c0_i         (chain[2]),
    .c1_i         (chain[3]),
    .c2_i         (chain[4]),
    .c3_i         (chain[5]),
    .ctl_o        (stk_ctl),
    .depth_o      (depth_d),
    .pops_o       (pops_d),
    .push_valid_o (pv_d),
    .push_value_o (pval_d),
    .exit_o       (ex_d),
    .status_o     (st_d)
  );

  // zero padding at both ends of the chain
  assign chain[0]              = '0;
  assign chain[1]              = '0;
  assign chain[RSTACK_DEPTH+2] = '0;
  assign chain[RSTACK_DEPTH+3] = '0;

  // return-stack cell chain
  for (genvar k = 0; k < RSTACK_DEPTH; k++) begin : g_cell
    logic        ld_en;
    logic [31:0] ld_val;
    if (k < LoadCells) begin : g_ld
      assign ld_en  = stk_ctl.ld_en[k];
      assign ld_val = stk_ctl.ld_val[k];
    end else begin : g_no_ld
      assign ld_en  = 1'b0;
      assign ld_val = '0;
    end
    smlb_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (stk_ctl.shift),
      .ld_en_i  (ld_en),
      .ld_val_i (ld_val),
      .up1_i    (chain[k+1]),
      .up2_i    (chain[k]),
      .dn1_i    (chain[k+3]),
      .dn2_i    (chain[k+4]),
      .q_o      (chain[k+2])
    );
  end

  // depth counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      done_q  <= 1'b0;
    end else begin
      depth_q <= depth_d;
      done_q  <= fire;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pops_q <= pops_d;
      pv_q   <= pv_d;
      pval_q <= pval_d;
      ex_q   <= ex_d;
      st_q   <= st_d;
    end
  end

  // pointer comes straight from the updated top cell
  assign done_o                = done_q;
  assign res_o.pointer_valid   = (depth_q != '0);
  assign res_o.next_pointer    = res_o.pointer_valid ? chain[2] : '0;
  assign res_o.data_pops       = pops_q;
  assign res_o.push_valid      = pv_q;
  assign res_o.push_value      = pval_q;
  assign res_o.exit_request    = ex_q;
  assign res_o.status          = st_q;

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(RSTACK_DEPTH))
    else $error("return stack depth beyond capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> done_o)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> !done_o)
    else $error("result without a transaction");

  a_missing_keeps_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == ST_MISSING |-> depth_q == $past(depth_q))
    else $error("depth changed on missing frame");

  a_push_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.push_valid |-> res_o.status == ST_OK)
    else $error("index push with error status");
`endif

endmodule

`default_nettype wire
